>>> src/tmbc_pkg.sv
// ----------------------------------------------------------------------------
// tmbc_pkg
// Shared types, constants and push arithmetic for the tile map box collision
// push block.
// ----------------------------------------------------------------------------
package tmbc_pkg;

   // Geometry; TILE_SIZE must be a power of two
   localparam int TILE_SIZE    = 64;
   localparam int BOX_SIZE     = 60;
   localparam int FRAC_BITS    = 8;
   localparam int MAX_COLS_DEF = 128;
   localparam int MAX_ROWS_DEF = 128;
   localparam int TILE_SHIFT   = $clog2(TILE_SIZE) + FRAC_BITS;

   localparam int POS_W       = 24;
   localparam int CORNER_W    = POS_W + 1;
   localparam int CALC_W      = 48;
   localparam int IDX_W       = 10;
   localparam int CNT_W       = 3;
   localparam int NCORNER     = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int CFG_W       = 8;
   localparam int CSR_IDX_W   = 8;

   localparam logic [CFG_W-1:0]     CFG_RESET    = CFG_W'(128);
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_COLS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_ROWS = CSR_IDX_W'(1);

   localparam logic signed [CALC_W-1:0] TILE_W = CALC_W'(longint'(TILE_SIZE) << FRAC_BITS);
   localparam logic signed [CALC_W-1:0] BOX_W  = CALC_W'(longint'(BOX_SIZE) << FRAC_BITS);
   localparam logic signed [CALC_W-1:0] SPAN_W = BOX_W + TILE_W;
   localparam logic signed [CALC_W-1:0] POS_MAX = CALC_W'(longint'(8388607));
   localparam logic signed [CALC_W-1:0] POS_MIN = -CALC_W'(longint'(8388608));

   typedef enum logic {
      MODE_WRITE = 1'b0,
      MODE_QUERY = 1'b1
   } mode_type;

   // One query on its way from the map lookup to the push stages
   typedef struct packed {
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
      logic [IDX_W-1:0]        tx0;
      logic [IDX_W-1:0]        tx1;
      logic [IDX_W-1:0]        ty0;
      logic [IDX_W-1:0]        ty1;
      logic [NCORNER-1:0]      hit;
      logic [CNT_W-1:0]        hit_count;
   } item_type;

   // Clamp to the signed position range
   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [CALC_W-1:0] v);
      logic signed [POS_W-1:0] r;
      if (v > POS_MAX) r = POS_W'(POS_MAX);
      else if (v < POS_MIN) r = POS_W'(POS_MIN);
      else r = POS_W'(v);
      return r;
   endfunction

   // Push the box out of the tile under corner k when that corner hit
   function automatic item_type push_corner(input item_type it, input logic [1:0] k);
      logic [IDX_W-1:0]         tx;
      logic [IDX_W-1:0]         ty;
      logic signed [CALC_W-1:0] pxw;
      logic signed [CALC_W-1:0] pyw;
      logic signed [CALC_W-1:0] dx;
      logic signed [CALC_W-1:0] dy;
      logic signed [CALC_W-1:0] ex;
      logic signed [CALC_W-1:0] ey;
      logic signed [CALC_W-1:0] m;
      item_type                 r;
      r   = it;
      tx  = k[0] ? it.tx1 : it.tx0;
      ty  = k[1] ? it.ty1 : it.ty0;
      pxw = CALC_W'($signed(it.px));
      pyw = CALC_W'($signed(it.py));
      // doubled-scale distance between box and tile centers
      dx  = (pxw <<< 1) + BOX_W - ($signed(CALC_W'(tx) << (TILE_SHIFT + 1)) + TILE_W);
      dy  = (pyw <<< 1) + BOX_W - ($signed(CALC_W'(ty) << (TILE_SHIFT + 1)) + TILE_W);
      ex  = SPAN_W - (dx < 0 ? -dx : dx);
      ey  = SPAN_W - (dy < 0 ? -dy : dy);
      if (it.hit[k] && ex > 0 && ey > 0) begin
         if (ex < ey) begin
            m    = (ex + CALC_W'(1)) >>> 1;
            r.px = sat_pos(dx < 0 ? pxw - m : pxw + m);
         end else begin
            m    = (ey + CALC_W'(1)) >>> 1;
            r.py = sat_pos(dy < 0 ? pyw - m : pyw + m);
         end
      end
      return r;
   endfunction

endpackage

>>> src/tmbc_ram.sv
// ----------------------------------------------------------------------------
// tmbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tmbc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16384
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

endmodule

>>> src/tmbc_front.sv
// ----------------------------------------------------------------------------
// tmbc_front
// Accepts transactions, keeps the solid-tile map, looks up the four corner
// tiles of a query and hands the classified query to the queue.
// ----------------------------------------------------------------------------
module tmbc_front #(
   parameter int MAX_COLS = tmbc_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = tmbc_pkg::MAX_ROWS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_mode,
   input  logic [6:0]                           req_tile_col,
   input  logic [6:0]                           req_tile_row,
   input  logic                                 req_tile_solid,
   input  logic signed [tmbc_pkg::POS_W-1:0]    req_pos_x,
   input  logic signed [tmbc_pkg::POS_W-1:0]    req_pos_y,
   input  logic [tmbc_pkg::CFG_W-1:0]           map_cols,
   input  logic [tmbc_pkg::CFG_W-1:0]           map_rows,
   input  logic [$clog2(tmbc_pkg::QUEUE_DEPTH):0] queue_count,
   output logic                                 push_valid,
   output tmbc_pkg::item_type                   push_item
);

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int DIM_W = $clog2(1024 + 1);
   localparam int CW    = tmbc_pkg::CORNER_W;

   logic          clear_ff, clear_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          f1_vld_ff, f1_vld_in;
   tmbc_pkg::item_type f1_item_ff, f1_item_in;
   logic [tmbc_pkg::NCORNER-1:0] inmap_ff, inmap_in;

   logic          accept;
   logic          wr_item;
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic          ram_wdata;
   logic [DIM_W-1:0] cols_eff, rows_eff;
   logic signed [CW-1:0] cx [2];
   logic signed [CW-1:0] cy [2];
   logic signed [CW-1:0] tx [2];
   logic signed [CW-1:0] ty [2];
   logic [1:0]    x_in, y_in;
   logic [AW-1:0] raddr [tmbc_pkg::NCORNER];
   logic [tmbc_pkg::NCORNER-1:0] rdata;
   logic [tmbc_pkg::NCORNER-1:0] hit;

   // Room for everything in flight before taking a new transaction
   assign req_ready = !clear_ff &&
      ((($clog2(tmbc_pkg::QUEUE_DEPTH) + 1)'(f1_vld_ff) + queue_count) <
       ($clog2(tmbc_pkg::QUEUE_DEPTH) + 1)'(tmbc_pkg::QUEUE_DEPTH));
   assign accept  = req_valid && req_ready;
   assign wr_item = accept && (req_mode == tmbc_pkg::MODE_WRITE) &&
                    (32'(req_tile_col) < MAX_COLS) && (32'(req_tile_row) < MAX_ROWS);

   // Saturate the map size registers
   assign cols_eff = (32'(map_cols) > MAX_COLS) ? DIM_W'(MAX_COLS) : DIM_W'(map_cols);
   assign rows_eff = (32'(map_rows) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : DIM_W'(map_rows);

   // Corner tiles: floor by arithmetic shift
   always_comb begin
      cx[0] = CW'(req_pos_x);
      cx[1] = CW'(req_pos_x) + CW'(tmbc_pkg::BOX_W);
      cy[0] = CW'(req_pos_y);
      cy[1] = CW'(req_pos_y) + CW'(tmbc_pkg::BOX_W);
      for (int i = 0; i < 2; i++) begin
         tx[i]   = cx[i] >>> tmbc_pkg::TILE_SHIFT;
         ty[i]   = cy[i] >>> tmbc_pkg::TILE_SHIFT;
         x_in[i] = !tx[i][CW-1] && (tx[i] < $signed(CW'(cols_eff)));
         y_in[i] = !ty[i][CW-1] && (ty[i] < $signed(CW'(rows_eff)));
      end
      for (int k = 0; k < tmbc_pkg::NCORNER; k++) begin
         inmap_in[k] = x_in[k % 2] && y_in[k / 2];
         raddr[k]    = inmap_in[k] ?
            AW'(32'(ty[k / 2][tmbc_pkg::IDX_W-1:0]) * MAX_COLS +
                32'(tx[k % 2][tmbc_pkg::IDX_W-1:0])) : '0;
      end
   end

   // Map write port: clearing pass first, then write transactions
   always_comb begin
      ram_we    = clear_ff || wr_item;
      ram_waddr = clear_ff ? clr_addr_ff :
                  AW'(32'(req_tile_row) * MAX_COLS + 32'(req_tile_col));
      ram_wdata = clear_ff ? 1'b0 : req_tile_solid;
   end

   // One full map copy per corner so all four read in the same cycle
   for (genvar k = 0; k < tmbc_pkg::NCORNER; k++) begin : g_map
      tmbc_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map (
         .clock    (clock),
         .we       (ram_we),
         .waddr    (ram_waddr),
         .wdata    (ram_wdata),
         .raddr    (raddr[k]),
         .rdata_ff (rdata[k])
      );
   end

   // Advance clearing counter and lookup stage
   always_comb begin
      clear_in    = clear_ff;
      clr_addr_in = clr_addr_ff;
      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (32'(clr_addr_ff) == DEPTH - 1) begin
            clear_in = 1'b0;
         end
      end
      f1_vld_in            = accept && (req_mode == tmbc_pkg::MODE_QUERY);
      f1_item_in           = '0;
      f1_item_in.px        = req_pos_x;
      f1_item_in.py        = req_pos_y;
      f1_item_in.tx0       = tx[0][tmbc_pkg::IDX_W-1:0];
      f1_item_in.tx1       = tx[1][tmbc_pkg::IDX_W-1:0];
      f1_item_in.ty0       = ty[0][tmbc_pkg::IDX_W-1:0];
      f1_item_in.ty1       = ty[1][tmbc_pkg::IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
         f1_vld_ff   <= 1'b0;
      end else begin
         clear_ff    <= clear_in;
         clr_addr_ff <= clr_addr_in;
         f1_vld_ff   <= f1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      f1_item_ff <= f1_item_in;
      inmap_ff   <= inmap_in;
   end

   // Classify corners once map data returns
   always_comb begin
      hit                  = inmap_ff & rdata;
      push_valid           = f1_vld_ff;
      push_item            = f1_item_ff;
      push_item.hit        = hit;
      push_item.hit_count  = tmbc_pkg::CNT_W'($countones(hit));
   end

endmodule

>>> src/tmbc_queue.sv
// ----------------------------------------------------------------------------
// tmbc_queue
// Short FIFO between lookup and push stages.
// ----------------------------------------------------------------------------
module tmbc_queue (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   push_valid,
   input  tmbc_pkg::item_type                     push_item,
   input  logic                                   pop,
   output logic                                   head_valid,
   output tmbc_pkg::item_type                     head_item,
   output logic [$clog2(tmbc_pkg::QUEUE_DEPTH):0] count
);

   localparam int PW = $clog2(tmbc_pkg::QUEUE_DEPTH);

   tmbc_pkg::item_type slot_ff [tmbc_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          do_pop;

   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rptr_ff];
   assign count      = count_ff;
   assign do_pop     = pop && head_valid;

   // Advance pointers and occupancy
   always_comb begin
      wptr_in  = push_valid ? wptr_ff + PW'(1) : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + PW'(1) : rptr_ff;
      count_in = count_ff + (PW + 1)'(push_valid) - (PW + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wptr_ff] <= push_item;
      end
   end

endmodule

>>> src/tmbc_back.sv
// ----------------------------------------------------------------------------
// tmbc_back
// Four push stages, one per corner in corner order; the last stage is the
// result register.
// ----------------------------------------------------------------------------
module tmbc_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   input  tmbc_pkg::item_type                head_item,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [tmbc_pkg::POS_W-1:0] rsp_new_pos_x,
   output logic signed [tmbc_pkg::POS_W-1:0] rsp_new_pos_y,
   output logic                              rsp_collided,
   output logic [tmbc_pkg::CNT_W-1:0]        rsp_hit_count
);

   localparam int NC = tmbc_pkg::NCORNER;

   tmbc_pkg::item_type st_ff [NC];
   tmbc_pkg::item_type st_in [NC];
   logic [NC-1:0] vld_ff, vld_in;
   logic          adv;

   // Whole pipe moves when the result register is free or taken
   assign adv = !vld_ff[NC-1] || rsp_ready;
   assign pop = adv;

   always_comb begin
      vld_in   = adv ? {vld_ff[NC-2:0], head_valid} : vld_ff;
      st_in[0] = tmbc_pkg::push_corner(head_item, 2'd0);
      for (int k = 1; k < NC; k++) begin
         st_in[k] = tmbc_pkg::push_corner(st_ff[k-1], 2'(k));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NC; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign rsp_valid     = vld_ff[NC-1];
   assign rsp_new_pos_x = st_ff[NC-1].px;
   assign rsp_new_pos_y = st_ff[NC-1].py;
   assign rsp_collided  = (st_ff[NC-1].hit != '0);
   assign rsp_hit_count = st_ff[NC-1].hit_count;

endmodule

>>> src/tile_map_box_collision_push.sv
// ----------------------------------------------------------------------------
// tile_map_box_collision_push
// Top level: solid-tile map, corner lookup, queue and push pipeline.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle once the map clearing pass after reset is
// done and while the lookup stage and queue have room; that pass writes one
// tile per cycle, with req_ready low throughout. Tile writes give no response.
// A query passes the map lookup, registered at its accepting edge, then the
// queue, then four push stages, one per corner; a four-entry queue between
// lookup and push lets both sides stall independently. The map is held in
// four copies so that all four corners read in the same cycle.
module tile_map_box_collision_push #(
   parameter int MAX_COLS = tmbc_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = tmbc_pkg::MAX_ROWS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_mode,
   input  logic [6:0]                          req_tile_col,
   input  logic [6:0]                          req_tile_row,
   input  logic                                req_tile_solid,
   input  logic signed [tmbc_pkg::POS_W-1:0]   req_pos_x,
   input  logic signed [tmbc_pkg::POS_W-1:0]   req_pos_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [tmbc_pkg::POS_W-1:0]   rsp_new_pos_x,
   output logic signed [tmbc_pkg::POS_W-1:0]   rsp_new_pos_y,
   output logic                                rsp_collided,
   output logic [tmbc_pkg::CNT_W-1:0]          rsp_hit_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tmbc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tmbc_pkg::CFG_W-1:0]          csr_data
);

   logic [tmbc_pkg::CFG_W-1:0] map_cols_ff, map_cols_in;
   logic [tmbc_pkg::CFG_W-1:0] map_rows_ff, map_rows_in;
   logic                       push_valid;
   tmbc_pkg::item_type         push_item;
   logic                       head_valid;
   tmbc_pkg::item_type         head_item;
   logic                       pop;
   logic [$clog2(tmbc_pkg::QUEUE_DEPTH):0] queue_count;

   // Map size registers
   assign csr_ready = 1'b1;

   always_comb begin
      map_cols_in = map_cols_ff;
      map_rows_in = map_rows_ff;
      if (csr_valid) begin
         if (csr_index == tmbc_pkg::CSR_MAP_COLS) map_cols_in = csr_data;
         if (csr_index == tmbc_pkg::CSR_MAP_ROWS) map_rows_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_cols_ff <= tmbc_pkg::CFG_RESET;
         map_rows_ff <= tmbc_pkg::CFG_RESET;
      end else begin
         map_cols_ff <= map_cols_in;
         map_rows_ff <= map_rows_in;
      end
   end

   tmbc_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_tile_col   (req_tile_col),
      .req_tile_row   (req_tile_row),
      .req_tile_solid (req_tile_solid),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .map_cols       (map_cols_ff),
      .map_rows       (map_rows_ff),
      .queue_count    (queue_count),
      .push_valid     (push_valid),
      .push_item      (push_item)
   );

   tmbc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .count      (queue_count)
   );

   tmbc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_new_pos_x (rsp_new_pos_x),
      .rsp_new_pos_y (rsp_new_pos_y),
      .rsp_collided  (rsp_collided),
      .rsp_hit_count (rsp_hit_count)
   );

endmodule

>>> src/tmbc_checker.sv
// ----------------------------------------------------------------------------
// tmbc_checker
// Port-level checks on the collision push block, bound to the top level.
// ----------------------------------------------------------------------------
module tmbc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [tmbc_pkg::POS_W-1:0] rsp_new_pos_x,
   input logic signed [tmbc_pkg::POS_W-1:0] rsp_new_pos_y,
   input logic                              rsp_collided,
   input logic [tmbc_pkg::CNT_W-1:0]        rsp_hit_count
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_pos_x) &&
      $stable(rsp_new_pos_y) && $stable(rsp_hit_count))
      else $error("stalled response changed");

   // Collided flag agrees with hit count
   a_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_collided == (rsp_hit_count != '0))
      else $error("collided flag and hit count disagree");

   // At most four corners hit
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hit_count <= tmbc_pkg::CNT_W'(tmbc_pkg::NCORNER))
      else $error("hit count above four");

   // Map clearing blocks input right after reset
   a_clear: assert property (@(posedge clock)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("activity right after reset");

endmodule

bind tile_map_box_collision_push tmbc_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_new_pos_x (rsp_new_pos_x),
   .rsp_new_pos_y (rsp_new_pos_y),
   .rsp_collided  (rsp_collided),
   .rsp_hit_count (rsp_hit_count)
);
